/* rtl/scp_pkg.sv */
// Package for the second-chance page buffer: command codes and default sizes.
// No dependencies; used by the top level and its checker.
package scp_pkg;

  localparam int SCP_SLOTS     = 4;
  localparam int SCP_PAGE_BITS = 24;
  localparam int CMD_W         = 2;
  localparam int CNT_W         = 32;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

endpackage

/* rtl/second_chance_page_buffer_top.sv */
// Second-chance page buffer tag and replacement engine, top level.
// Depends on scp_pkg for command codes and default sizes.
//
//   port group   dir  handshake            carries
//   request      in   in_valid / in_ready  cmd, page_number, root_page, newest_page
//   result       out  out_valid/out_ready  hit .. last, one or more per request
//
// A request moves from the input register to the result register;
// read and write requests sustain one transfer per cycle unless the result register stalls.
// A flush gives one result per dirty page (one result if none is dirty), one per
// cycle unless stalled, and holds the input register until its last result is loaded.
// A stalled result register holds the input register; the input register still
// takes a transfer while the result register is free or draining.
// Synchronous reset empties every slot and clears both counters.
module second_chance_page_buffer_top
  import scp_pkg::*;
#(
  parameter int SLOTS     = SCP_SLOTS,
  parameter int PAGE_BITS = SCP_PAGE_BITS,
  localparam int SlotW    = $clog2(SLOTS + 2)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CMD_W-1:0]            cmd,
  input  logic signed [PAGE_BITS-1:0] page_number,
  input  logic signed [PAGE_BITS-1:0] root_page,
  input  logic signed [PAGE_BITS-1:0] newest_page,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic                        fault,
  output logic [SlotW-1:0]            slot_used,
  output logic                        disk_read,
  output logic                        immediate_write,
  output logic                        writeback_valid,
  output logic signed [PAGE_BITS-1:0] writeback_page,
  output logic [CNT_W-1:0]            hit_total,
  output logic [CNT_W-1:0]            fault_total,
  output logic                        last
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int Msb  = PAGE_BITS - 1;
  localparam logic [SlotW-1:0] SlotPinned = SlotW'(SLOTS);
  localparam logic [SlotW-1:0] SlotNone   = SlotW'(SLOTS + 1);

  logic                 in_vld;
  logic [CMD_W-1:0]     in_cmd;
  logic [PAGE_BITS-1:0] in_page;
  logic [PAGE_BITS-1:0] in_root;
  logic [PAGE_BITS-1:0] in_newest;

  logic [PAGE_BITS-1:0] slot_page [SLOTS];
  logic [PAGE_BITS-1:0] slot_page_next [SLOTS];
  logic [SLOTS-1:0]     slot_dirty, slot_dirty_next;
  logic [SLOTS-1:0]     slot_evict, slot_evict_next;
  logic [PAGE_BITS-1:0] pinned_page, pinned_page_next;
  logic                 pinned_dirty, pinned_dirty_next;
  logic [CNT_W-1:0]     hit_cnt, hit_cnt_next;
  logic [CNT_W-1:0]     fault_cnt, fault_cnt_next;
  logic [SLOTS:0]       flush_mask, flush_mask_next;

  logic                 out_free, consume, emit_flush;

  logic                 r_hit, r_fault, r_rd, r_iw, r_wbv, r_last;
  logic [SlotW-1:0]     r_slot;
  logic [PAGE_BITS-1:0] r_wbp;
  logic [PAGE_BITS-1:0] wbp_q;

  logic                 pin_hit, fifo_hit, free_found, ev_found, is_write, new_dirty;
  logic [IdxW-1:0]      hit_idx, free_idx, victim;
  logic [SLOTS-1:0]     ev_scan;
  logic                 vic_dirty;
  logic [PAGE_BITS-1:0] vic_page;
  logic [SLOTS:0]       dirty_all, pick, pick_rest;
  logic                 pick_found;
  logic [SlotW-1:0]     pick_slot;
  logic [PAGE_BITS-1:0] pick_page;

  assign out_free   = !out_valid || out_ready;
  assign emit_flush = (|flush_mask) && out_free;
  assign consume    = in_vld && !(|flush_mask) && out_free;
  assign in_ready   = !in_vld || consume;

  always_comb begin
    pin_hit    = pinned_page == in_page;
    fifo_hit   = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    ev_found   = 1'b0;
    victim     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!fifo_hit && slot_page[i] == in_page) begin
        fifo_hit = 1'b1;
        hit_idx  = IdxW'(i);
      end
      if (!free_found && slot_page[i][Msb]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
      if (!ev_found && slot_evict[i]) begin
        ev_found = 1'b1;
        victim   = IdxW'(i);
      end
    end
    vic_dirty = 1'b0;
    vic_page  = '1;
    for (int i = 0; i < SLOTS; i++) begin
      ev_scan[i] = (!ev_found || i < int'(victim)) ? 1'b1 : slot_evict[i];
      if (i == int'(victim)) begin
        vic_dirty = slot_dirty[i];
        vic_page  = slot_page[i];
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      dirty_all[i] = !slot_page[i][Msb] && slot_dirty[i];
    end
    dirty_all[SLOTS] = !pinned_page[Msb] && pinned_dirty;
  end

  always_comb begin
    pick       = emit_flush ? flush_mask : dirty_all;
    pick_rest  = pick;
    pick_found = 1'b0;
    pick_slot  = SlotNone;
    pick_page  = '1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!pick_found && pick[i]) begin
        pick_found   = 1'b1;
        pick_slot    = SlotW'(i);
        pick_page    = slot_page[i];
        pick_rest[i] = 1'b0;
      end
    end
    if (!pick_found && pick[SLOTS]) begin
      pick_found       = 1'b1;
      pick_slot        = SlotPinned;
      pick_page        = pinned_page;
      pick_rest[SLOTS] = 1'b0;
    end
  end

  always_comb begin
    is_write          = in_cmd == CMD_WRITE;
    new_dirty         = is_write && in_page != in_newest;
    slot_page_next    = slot_page;
    slot_dirty_next   = slot_dirty;
    slot_evict_next   = slot_evict;
    pinned_page_next  = pinned_page;
    pinned_dirty_next = pinned_dirty;
    hit_cnt_next      = hit_cnt;
    fault_cnt_next    = fault_cnt;
    flush_mask_next   = flush_mask;
    r_hit             = 1'b0;
    r_fault           = 1'b0;
    r_slot            = SlotNone;
    r_rd              = 1'b0;
    r_iw              = 1'b0;
    r_wbv             = 1'b0;
    r_wbp             = '1;
    r_last            = 1'b1;

    if (emit_flush || (consume && in_cmd == CMD_FLUSH)) begin
      if (pick_found) begin
        r_slot          = pick_slot;
        r_wbv           = 1'b1;
        r_wbp           = pick_page;
        r_last          = !(|pick_rest);
        flush_mask_next = pick_rest;
      end
    end else if (consume) begin
      case (in_cmd)
        CMD_READ, CMD_WRITE: begin
          if (in_page[Msb]) begin
            r_slot = SlotNone;
          end else if (pin_hit) begin
            hit_cnt_next = hit_cnt + 1'b1;
            if (is_write) begin
              pinned_dirty_next = 1'b1;
            end
            r_hit  = 1'b1;
            r_slot = SlotPinned;
          end else if (fifo_hit) begin
            hit_cnt_next = hit_cnt + 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
              if (i == int'(hit_idx)) begin
                slot_evict_next[i] = 1'b0;
                if (is_write) begin
                  slot_dirty_next[i] = 1'b1;
                end
              end
            end
            r_hit  = 1'b1;
            r_slot = SlotW'(hit_idx);
          end else begin
            fault_cnt_next = fault_cnt + 1'b1;
            r_fault        = 1'b1;
            r_rd           = !is_write;
            r_iw           = is_write && in_page == in_newest;
            if (in_page == in_root) begin
              if (!pinned_page[Msb] && pinned_dirty) begin
                r_wbv = 1'b1;
                r_wbp = pinned_page;
              end
              pinned_page_next  = in_page;
              pinned_dirty_next = new_dirty;
              r_slot            = SlotPinned;
            end else if (free_found) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (i == int'(free_idx)) begin
                  slot_page_next[i]  = in_page;
                  slot_dirty_next[i] = new_dirty;
                  slot_evict_next[i] = 1'b1;
                end
              end
              r_slot = SlotW'(free_idx);
            end else begin
              if (vic_dirty) begin
                r_wbv = 1'b1;
                r_wbp = vic_page;
              end
              for (int i = 0; i < SLOTS - 1; i++) begin
                if (i < int'(victim)) begin
                  slot_evict_next[i] = ev_scan[i];
                end else begin
                  slot_page_next[i]  = slot_page[i+1];
                  slot_dirty_next[i] = slot_dirty[i+1];
                  slot_evict_next[i] = ev_scan[i+1];
                end
              end
              slot_page_next[SLOTS-1]  = in_page;
              slot_dirty_next[SLOTS-1] = new_dirty;
              slot_evict_next[SLOTS-1] = 1'b1;
              r_slot                   = SlotW'(SLOTS - 1);
            end
          end
        end
        default: begin
          r_slot = SlotNone;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_cmd    <= cmd;
      in_page   <= $unsigned(page_number);
      in_root   <= $unsigned(root_page);
      in_newest <= $unsigned(newest_page);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_page[i] <= '1;
      end
      slot_dirty   <= '0;
      slot_evict   <= '0;
      pinned_page  <= '1;
      pinned_dirty <= 1'b0;
      hit_cnt      <= '0;
      fault_cnt    <= '0;
      flush_mask   <= '0;
    end else begin
      slot_page    <= slot_page_next;
      slot_dirty   <= slot_dirty_next;
      slot_evict   <= slot_evict_next;
      pinned_page  <= pinned_page_next;
      pinned_dirty <= pinned_dirty_next;
      hit_cnt      <= hit_cnt_next;
      fault_cnt    <= fault_cnt_next;
      flush_mask   <= flush_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_flush || consume) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit_flush || consume) begin
      hit             <= r_hit;
      fault           <= r_fault;
      slot_used       <= r_slot;
      disk_read       <= r_rd;
      immediate_write <= r_iw;
      writeback_valid <= r_wbv;
      wbp_q           <= r_wbp;
      hit_total       <= hit_cnt_next;
      fault_total     <= fault_cnt_next;
      last            <= r_last;
    end
  end

  assign writeback_page = $signed(wbp_q);

endmodule

/* rtl/scp_checker.sv */
// Port-level checker for the second-chance page buffer, bound to the top level.
// Depends on scp_pkg for the default sizes.
module scp_checker
  import scp_pkg::*;
#(
  parameter int SLOTS     = SCP_SLOTS,
  parameter int PAGE_BITS = SCP_PAGE_BITS,
  localparam int SlotW    = $clog2(SLOTS + 2)
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic                        fault,
  input logic [SlotW-1:0]            slot_used,
  input logic                        disk_read,
  input logic                        immediate_write,
  input logic                        writeback_valid,
  input logic signed [PAGE_BITS-1:0] writeback_page,
  input logic [CNT_W-1:0]            hit_total,
  input logic [CNT_W-1:0]            fault_total,
  input logic                        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot_used) && $stable(writeback_page)
      && $stable(last) && $stable(hit_total) && $stable(fault_total))
    else $error("result changed while stalled");

  a_hit_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && (hit || fault) |-> !(hit && fault) && last && slot_used != SlotW'(SLOTS + 1))
    else $error("bad hit or fault result");

  a_wb_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !writeback_valid |-> writeback_page == -1)
    else $error("write-back page set without write-back");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (disk_read || immediate_write) |-> fault && !(disk_read && immediate_write))
    else $error("disk flags outside a fault");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready ##1 out_valid && hit |-> hit_total == $past(hit_total) + 1'b1)
    else $error("hit count did not advance");

endmodule

bind second_chance_page_buffer_top scp_checker #(
  .SLOTS(SLOTS),
  .PAGE_BITS(PAGE_BITS)
) u_scp_checker (.*);

/* test/second_chance_page_buffer_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for second_chance_page_buffer_top: random and directed requests,
// with the expected results predicted by a scoreboard class inside the bench.
// Depends on scp_pkg and the top level in rtl/.
module second_chance_page_buffer_top_tb;
  import scp_pkg::*;

  localparam int PB        = SCP_PAGE_BITS;
  localparam int SLOT_W    = $clog2(SCP_SLOTS + 2);
  localparam int SLOT_PIN  = SCP_SLOTS;
  localparam int SLOT_NONE = SCP_SLOTS + 1;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic signed [PB-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  typedef struct {
    logic             hit;
    logic             fault;
    slot_t            slot;
    logic             disk_read;
    logic             imm_write;
    logic             wb_valid;
    page_t            wb_page;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] fault_total;
    logic             last;
  } result_t;

  class page_buffer_scoreboard;
    page_t            slot_pg[SCP_SLOTS];
    bit               slot_dirty[SCP_SLOTS];
    bit               slot_evict[SCP_SLOTS];
    page_t            pin_pg;
    bit               pin_dirty;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] faults;
    result_t          due_results[$];
    int               errors;
    int               checked;
    int               flushes;

    function new();
      for (int i = 0; i < SCP_SLOTS; i++) begin
        slot_pg[i]    = '1;
        slot_dirty[i] = 1'b0;
        slot_evict[i] = 1'b0;
      end
      pin_pg    = '1;
      pin_dirty = 1'b0;
      hits      = '0;
      faults    = '0;
      errors    = 0;
      checked   = 0;
      flushes   = 0;
    endfunction

    function void push(bit h, bit f, int s, bit rd, bit iw, bit wbv, page_t wbp, bit lst);
      result_t r;
      r.hit         = h;
      r.fault       = f;
      r.slot        = slot_t'(s);
      r.disk_read   = rd;
      r.imm_write   = iw;
      r.wb_valid    = wbv;
      r.wb_page     = wbv ? wbp : '1;
      r.hit_total   = hits;
      r.fault_total = faults;
      r.last        = lst;
      due_results.push_back(r);
    endfunction

    function int place_in_fifo(page_t pg, bit dirty, inout bit wbv, inout page_t wbp);
      int victim;
      victim = -1;
      for (int i = 0; i < SCP_SLOTS; i++) begin
        if (slot_pg[i][PB-1]) begin
          slot_pg[i]    = pg;
          slot_dirty[i] = dirty;
          slot_evict[i] = 1'b1;
          return i;
        end
      end
      for (int i = 0; i < SCP_SLOTS; i++) begin
        if (slot_evict[i]) begin
          victim = i;
          break;
        end
        slot_evict[i] = 1'b1;
      end
      if (victim < 0) victim = 0;
      if (slot_dirty[victim]) begin
        wbv = 1'b1;
        wbp = slot_pg[victim];
      end
      for (int i = victim; i < SCP_SLOTS - 1; i++) begin
        slot_pg[i]    = slot_pg[i+1];
        slot_dirty[i] = slot_dirty[i+1];
        slot_evict[i] = slot_evict[i+1];
      end
      slot_pg[SCP_SLOTS-1]    = pg;
      slot_dirty[SCP_SLOTS-1] = dirty;
      slot_evict[SCP_SLOTS-1] = 1'b1;
      return SCP_SLOTS - 1;
    endfunction

    function void note_request(cmd_t c, page_t pg, page_t root, page_t newest);
      int    n;
      int    s;
      bit    wr;
      bit    dirty;
      bit    iw;
      bit    wbv;
      page_t wbp;
      if (c == CMD_FLUSH) begin
        flushes++;
        n = 0;
        for (int i = 0; i < SCP_SLOTS; i++) begin
          if (!slot_pg[i][PB-1] && slot_dirty[i]) begin
            push(0, 0, i, 0, 0, 1, slot_pg[i], 0);
            n++;
          end
        end
        if (!pin_pg[PB-1] && pin_dirty) begin
          push(0, 0, SLOT_PIN, 0, 0, 1, pin_pg, 0);
          n++;
        end
        if (n == 0) push(0, 0, SLOT_NONE, 0, 0, 0, '1, 1);
        else due_results[due_results.size()-1].last = 1'b1;
        return;
      end
      if (c == CMD_NONE || pg[PB-1]) begin
        push(0, 0, SLOT_NONE, 0, 0, 0, '1, 1);
        return;
      end
      wr = (c == CMD_WRITE);
      if (pin_pg == pg) begin
        hits++;
        if (wr) pin_dirty = 1'b1;
        push(1, 0, SLOT_PIN, 0, 0, 0, '1, 1);
        return;
      end
      for (int i = 0; i < SCP_SLOTS; i++) begin
        if (slot_pg[i] == pg) begin
          hits++;
          if (wr) slot_dirty[i] = 1'b1;
          slot_evict[i] = 1'b0;
          push(1, 0, i, 0, 0, 0, '1, 1);
          return;
        end
      end
      faults++;
      iw    = wr && (pg == newest);
      dirty = wr && (pg != newest);
      wbv   = 1'b0;
      wbp   = '1;
      if (pg == root) begin
        if (!pin_pg[PB-1] && pin_dirty) begin
          wbv = 1'b1;
          wbp = pin_pg;
        end
        pin_pg    = pg;
        pin_dirty = dirty;
        s         = SLOT_PIN;
      end else begin
        s = place_in_fifo(pg, dirty, wbv, wbp);
      end
      push(0, 1, s, !wr, iw, wbv, wbp, 1);
    endfunction

    function void check_field(string name, logic signed [63:0] e, logic signed [63:0] a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = due_results.pop_front();
      checked++;
      check_field("hit", e.hit, a.hit);
      check_field("fault", e.fault, a.fault);
      check_field("slot_used", e.slot, a.slot);
      check_field("disk_read", e.disk_read, a.disk_read);
      check_field("immediate_write", e.imm_write, a.imm_write);
      check_field("writeback_valid", e.wb_valid, a.wb_valid);
      check_field("writeback_page", e.wb_page, a.wb_page);
      check_field("hit_total", e.hit_total, a.hit_total);
      check_field("fault_total", e.fault_total, a.fault_total);
      check_field("last", e.last, a.last);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  cmd_t             cmd;
  page_t            page_number;
  page_t            root_page;
  page_t            newest_page;
  logic             out_valid;
  logic             out_ready;
  logic             hit;
  logic             fault;
  slot_t            slot_used;
  logic             disk_read;
  logic             immediate_write;
  logic             writeback_valid;
  page_t            writeback_page;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] fault_total;
  logic             last;

  page_buffer_scoreboard sb = new();
  bit idle_on = 1'b1;
  int requests = 0;
  int nulls = 0;

  second_chance_page_buffer_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int stall_left;
    result_t act;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        act.hit         = hit;
        act.fault       = fault;
        act.slot        = slot_used;
        act.disk_read   = disk_read;
        act.imm_write   = immediate_write;
        act.wb_valid    = writeback_valid;
        act.wb_page     = writeback_page;
        act.hit_total   = hit_total;
        act.fault_total = fault_total;
        act.last        = last;
        sb.check_result(act);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic issue_request(cmd_t c, page_t pg, page_t root, page_t newest);
    in_valid    <= 1'b1;
    cmd         <= c;
    page_number <= pg;
    root_page   <= root;
    newest_page <= newest;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(c, pg, root, newest);
    requests++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  task automatic run_directed();
    issue_request(CMD_FLUSH, 0, 100, 0);
    issue_request(CMD_READ, -1, 100, 0);
    issue_request(CMD_NONE, 5, 100, 0);
    issue_request(CMD_WRITE, 1, 100, 1);
    issue_request(CMD_WRITE, 2, 100, 0);
    issue_request(CMD_READ, 3, 100, 0);
    issue_request(CMD_READ, 8388607, -1, 0);
    issue_request(CMD_READ, 1, 100, 0);
    issue_request(CMD_WRITE, 3, 100, 3);
    issue_request(CMD_READ, 4, 100, 0);
    issue_request(CMD_WRITE, 100, 100, 0);
    issue_request(CMD_READ, 100, 100, 0);
    issue_request(CMD_FLUSH, 0, 100, 0);
    issue_request(CMD_READ, 1, 100, 0);
    issue_request(CMD_READ, 3, 100, 0);
    issue_request(CMD_READ, 8388607, 100, 0);
    issue_request(CMD_READ, 4, 100, 0);
    issue_request(CMD_WRITE, 5, 100, 7);
    issue_request(CMD_READ, 200, 200, 0);
    issue_request(CMD_WRITE, 0, -1, -1);
    issue_request(CMD_READ, 0, 8388607, 8388607);
    issue_request(CMD_FLUSH, -1, 0, -1);
    issue_request(CMD_WRITE, 8388607, 0, 8388607);
    issue_request(CMD_NONE, -8388608, -8388608, -8388608);
  endtask

  task automatic run_random();
    page_t pool[8];
    page_t root;
    page_t pg;
    page_t newest;
    cmd_t  c;
    int    n;
    int    it;
    int    r;
    bit    paused;
    bit    is_null;
    pool   = '{0, 1, 2, 3, 77, 4096, 1000000, 8388607};
    root   = pool[2];
    n      = 0;
    it     = 0;
    paused = 1'b0;
    while (n < 410) begin
      it++;
      if (it % 40 == 0) idle_on = $urandom_range(0, 3) != 0;
      if (n >= 350) idle_on = 1'b0;
      if (!paused && n >= 200) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        wait_for_results();
      end
      if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 3))
          0: root = -1;
          1: root = page_t'($urandom);
          default: root = pool[$urandom_range(0, 7)];
        endcase
      end
      if ($urandom_range(0, 19) == 0)
        pool[$urandom_range(0, 7)] = page_t'($urandom_range(0, 8388607));
      r = $urandom_range(0, 99);
      is_null = 1'b0;
      if (r < 6) begin
        c  = CMD_FLUSH;
        pg = page_t'($urandom);
      end else if (r < 10) begin
        is_null = 1'b1;
        c  = $urandom_range(0, 1) ? CMD_NONE : cmd_t'($urandom_range(0, 1));
        pg = page_t'($urandom);
        if (c != CMD_NONE) pg[PB-1] = 1'b1;
      end else begin
        c = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        if ($urandom_range(0, 9) == 0 && !root[PB-1]) pg = root;
        else if ($urandom_range(0, 4) == 0) pg = page_t'($urandom_range(0, 8388607));
        else pg = pool[$urandom_range(0, 7)];
      end
      newest = ($urandom_range(0, 2) == 0) ? pg : page_t'($urandom);
      issue_request(c, pg, root, newest);
      if (is_null) nulls++;
      else n++;
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    cmd         <= CMD_READ;
    page_number <= '0;
    root_page   <= '0;
    newest_page <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("covered %0d requests (%0d flushes, %0d null or unknown), %0d results checked",
             requests, sb.flushes, nulls, sb.checked);
    $display("buffer saw %0d hits and %0d faults", sb.hits, sb.faults);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
